@@ sv/pbfsh_pkg.sv @@
package pbfsh_pkg;

  localparam int SLOT_COUNT_DEFAULT  = 8;
  localparam int KEY_BITS_DEFAULT    = 16;
  localparam int STREAK_BITS_DEFAULT = 8;

  localparam int KEY_FIELD_W    = 16;
  localparam int KIND_W         = 4;
  localparam int CODE_W         = 3;
  localparam int STREAK_FIELD_W = 8;
  localparam int SLOT_FIELD_W   = 3;
  localparam int THR_W          = 8;
  localparam int CFG_INDEX_W    = 2;

  localparam int IN_FIELDS_W  = KEY_FIELD_W + KIND_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + CODE_W + STREAK_FIELD_W + SLOT_FIELD_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEGRADED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CRITICAL = 2'd1;

  localparam logic [THR_W-1:0] DEGRADED_RESET = 8'd3;
  localparam logic [THR_W-1:0] CRITICAL_RESET = 8'd5;

  localparam logic [KIND_W-1:0] EV_NONE          = 4'd0;
  localparam logic [KIND_W-1:0] EV_ENTERED       = 4'd1;
  localparam logic [KIND_W-1:0] EV_OK            = 4'd2;
  localparam logic [KIND_W-1:0] EV_COMPLETED     = 4'd3;
  localparam logic [KIND_W-1:0] EV_TIMEOUT       = 4'd4;
  localparam logic [KIND_W-1:0] EV_OUT_OF_BOUNDS = 4'd5;
  localparam logic [KIND_W-1:0] EV_ARENA         = 4'd6;
  localparam logic [KIND_W-1:0] EV_MEMFAULT      = 4'd7;
  localparam logic [KIND_W-1:0] EV_PANIC         = 4'd8;
  localparam logic [KIND_W-1:0] EV_FAULT         = 4'd9;
  localparam logic [KIND_W-1:0] EV_ERROR         = 4'd10;
  localparam logic [KIND_W-1:0] EV_UNSUPPORTED   = 4'd11;

  localparam logic [CODE_W-1:0] HC_OK       = 3'd0;
  localparam logic [CODE_W-1:0] HC_RUNNING  = 3'd1;
  localparam logic [CODE_W-1:0] HC_TIMEOUT  = 3'd2;
  localparam logic [CODE_W-1:0] HC_FAULT    = 3'd3;
  localparam logic [CODE_W-1:0] HC_DEGRADED = 3'd4;
  localparam logic [CODE_W-1:0] HC_CRITICAL = 3'd5;

endpackage

@@ sv/pbfsh_ram.sv @@
module pbfsh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/per_block_failure_streak_health.sv @@
// flow: a request is taken in idle, then slots are scanned from slot 0 and the scan stops at a
// hit; a new key scans all SLOT_COUNT slots and takes the first free one, and a key meeting
// a full table shares slot 0 after a further read of it; the result waits for a free output
// requests are handled one at a time, the next one taken once the result is written
// a finished result waits in the output register while the next request is taken
// reset (synchronous, active high) frees all slots and restores thresholds 3 and 5
module per_block_failure_streak_health #(
  parameter int SLOT_COUNT  = pbfsh_pkg::SLOT_COUNT_DEFAULT,
  parameter int KEY_BITS    = pbfsh_pkg::KEY_BITS_DEFAULT,
  parameter int STREAK_BITS = pbfsh_pkg::STREAK_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // block_key, event_kind
  input  logic [pbfsh_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // health_valid, health_code, streak_count, slot_index
  output logic [pbfsh_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pbfsh_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pbfsh_pkg::THR_W-1:0]        cfg_data
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int WW = KEY_BITS + STREAK_BITS;
  localparam int CW = (STREAK_BITS > pbfsh_pkg::THR_W) ? STREAK_BITS : pbfsh_pkg::THR_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
  localparam logic [STREAK_BITS-1:0] STREAK_MAX = '1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_READ0, ST_UPDATE} state_t;

  state_t state;
  logic [pbfsh_pkg::THR_W-1:0]  degraded_thr;
  logic [pbfsh_pkg::THR_W-1:0]  critical_thr;
  logic [SLOT_COUNT-1:0]        slot_used;
  logic [KEY_BITS-1:0]          key;
  logic [pbfsh_pkg::KIND_W-1:0] kind;
  logic [IW-1:0]                cmp_idx;
  logic                         free_found;
  logic [IW-1:0]                open_idx;
  logic [IW-1:0]                slot;
  logic [STREAK_BITS-1:0]       cur_streak;
  logic [KEY_BITS-1:0]          wkey;

  logic [IW-1:0]                raddr;
  logic [WW-1:0]                rdata;
  logic [KEY_BITS-1:0]          rd_key;
  logic [STREAK_BITS-1:0]       rd_streak;
  logic                         hit;
  logic                         cur_free;
  logic                         last;
  logic                         out_free;
  logic                         ram_we;

  logic                         bump;
  logic                         clear;
  logic                         hv;
  logic [pbfsh_pkg::CODE_W-1:0] code;
  logic [STREAK_BITS-1:0]       streak_next;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign rd_key    = rdata[KEY_BITS-1:0];
  assign rd_streak = rdata[WW-1:KEY_BITS];
  assign hit       = slot_used[cmp_idx] && (rd_key == key);
  assign cur_free  = !slot_used[cmp_idx];
  assign last      = (cmp_idx == LAST_IDX);
  assign out_free  = !m_tvalid || m_tready;
  assign ram_we    = (state == ST_UPDATE) && out_free;
  assign raddr     = (state == ST_SCAN && !hit && !last) ? cmp_idx + 1'b1 : '0;

  pbfsh_ram #(
    .WIDTH (WW),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata ({streak_next, wkey}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    bump  = 1'b0;
    clear = 1'b0;
    hv    = 1'b0;
    code  = pbfsh_pkg::HC_OK;
    case (kind)
      pbfsh_pkg::EV_ENTERED: begin
        hv   = 1'b1;
        code = pbfsh_pkg::HC_RUNNING;
      end
      pbfsh_pkg::EV_OK: begin
        clear = 1'b1;
        hv    = 1'b1;
        code  = pbfsh_pkg::HC_OK;
      end
      pbfsh_pkg::EV_TIMEOUT: begin
        bump = 1'b1;
        hv   = 1'b1;
        code = pbfsh_pkg::HC_TIMEOUT;
      end
      pbfsh_pkg::EV_OUT_OF_BOUNDS, pbfsh_pkg::EV_ARENA, pbfsh_pkg::EV_MEMFAULT,
      pbfsh_pkg::EV_PANIC, pbfsh_pkg::EV_FAULT, pbfsh_pkg::EV_ERROR: begin
        bump = 1'b1;
        hv   = 1'b1;
        code = pbfsh_pkg::HC_FAULT;
      end
      pbfsh_pkg::EV_UNSUPPORTED: begin
        bump = 1'b1;
        hv   = 1'b1;
        code = pbfsh_pkg::HC_DEGRADED;
      end
      default: begin
        bump = 1'b0;
      end
    endcase

    if (clear) begin
      streak_next = '0;
    end else if (bump && cur_streak != STREAK_MAX) begin
      streak_next = cur_streak + 1'b1;
    end else begin
      streak_next = cur_streak;
    end

    if (CW'(streak_next) >= CW'(critical_thr)) begin
      hv   = 1'b1;
      code = pbfsh_pkg::HC_CRITICAL;
    end else if (CW'(streak_next) >= CW'(degraded_thr)) begin
      hv   = 1'b1;
      code = pbfsh_pkg::HC_DEGRADED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      degraded_thr <= pbfsh_pkg::DEGRADED_RESET;
      critical_thr <= pbfsh_pkg::CRITICAL_RESET;
      slot_used    <= '0;
      free_found   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == pbfsh_pkg::CFG_DEGRADED) begin
          degraded_thr <= cfg_data;
        end else if (cfg_index == pbfsh_pkg::CFG_CRITICAL) begin
          critical_thr <= cfg_data;
        end
      end

      if (m_tvalid && m_tready && !ram_we) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            key        <= KEY_BITS'(s_tdata[pbfsh_pkg::KEY_FIELD_W-1:0]);
            kind       <= s_tdata[pbfsh_pkg::IN_FIELDS_W-1:pbfsh_pkg::KEY_FIELD_W];
            cmp_idx    <= '0;
            free_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            slot       <= cmp_idx;
            cur_streak <= rd_streak;
            wkey       <= key;
            state      <= ST_UPDATE;
          end else begin
            if (cur_free && !free_found) begin
              free_found <= 1'b1;
              open_idx   <= cmp_idx;
            end
            if (last) begin
              if (free_found || cur_free) begin
                slot       <= free_found ? open_idx : cmp_idx;
                cur_streak <= '0;
                wkey       <= key;
                state      <= ST_UPDATE;
              end else begin
                state <= ST_READ0;
              end
            end else begin
              cmp_idx <= cmp_idx + 1'b1;
            end
          end
        end
        ST_READ0: begin
          // table full: share slot 0 and keep its key
          slot       <= '0;
          cur_streak <= rd_streak;
          wkey       <= rd_key;
          state      <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            slot_used[slot] <= 1'b1;
            free_found      <= 1'b0;
            m_tvalid        <= 1'b1;
            m_tdata         <= {{(pbfsh_pkg::OUT_TDATA_W - pbfsh_pkg::OUT_FIELDS_W){1'b0}},
                                pbfsh_pkg::SLOT_FIELD_W'(slot),
                                pbfsh_pkg::STREAK_FIELD_W'(streak_next),
                                code, hv};
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_reset_no_output: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_write_marks_used: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> slot_used[$past(slot)])
    else $error("written slot not marked used");

  a_free_slot_unused: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && free_found) |-> !slot_used[open_idx])
    else $error("recorded free slot is in use");

  a_no_accept_on_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !s_tready)
    else $error("request taken during slot write back");
`endif

endmodule
